// File: src/cgc_pkg.sv
package cgc_pkg;

  localparam int unsigned MAX_NODES    = 1024;
  localparam int unsigned MAX_CLUSTERS = 64;
  localparam int unsigned NODE_AW      = $clog2(MAX_NODES);
  localparam int unsigned CLU_W        = $clog2(MAX_CLUSTERS);
  localparam int unsigned PAIR_AW      = 2 * CLU_W;
  localparam int unsigned PAIR_DEPTH   = MAX_CLUSTERS * MAX_CLUSTERS;
  localparam int unsigned CC_W         = 7;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned WGT_W        = 64;
  localparam logic [CC_W-1:0]  CC_RESET  = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MAX   = 11'd2047;

  typedef enum logic [1:0] {
    OP_MAP = 2'd0,
    OP_ARC = 2'd1,
    OP_QRY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAME  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_RMW   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [9:0]        first_node;
    logic [9:0]        second_node;
    logic [5:0]        cluster_id;
    logic signed [31:0] arc_weight;
    logic [5:0]        query_from;
    logic [5:0]        query_to;
  } item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [WGT_W-1:0] weight_forward;
    logic signed [WGT_W-1:0] weight_reverse;
    logic                    pair_present;
    logic [CNT_W-1:0]        pair_total;
    logic [CNT_W-1:0]        from_node_total;
    logic [CNT_W-1:0]        to_node_total;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic               accept;    // latch item, launch first memory reads
    logic               look_fin;  // finish item after lookup, load result
    logic               arc_rd;    // read pair accumulator for an arc
    logic               rmw_fin;   // write back accumulator, load result
    logic               clr_en;    // clearing pass write
    logic [PAIR_AW-1:0] clr_addr;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] opcode;
    logic       arc_ok;
  } sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  function automatic logic clu_bad(input logic [CLU_W-1:0] id, input logic [CC_W-1:0] cc);
    clu_bad = ({{(CC_W-CLU_W){1'b0}}, id} >= cc);
  endfunction

endpackage

// File: src/cgc_ctrl.sv
module cgc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  output logic          in_ready,
  input  logic          out_tready,
  output logic          out_valid,
  input  cgc_pkg::sts_t sts,
  output cgc_pkg::cmd_t cmd
);
  import cgc_pkg::*;

  state_t             state_r, state_nxt;
  logic [PAIR_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cmd          = '0;
    cmd.clr_addr = clr_addr_r;
    cmd.accept   = in_fire;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en   = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == PAIR_AW'(PAIR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.arc_ok) begin
          cmd.arc_rd = 1'b1;
          state_nxt  = S_RMW;
        end else if (out_free) begin
          cmd.look_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RMW: begin
        if (out_free) begin
          cmd.rmw_fin = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.look_fin || cmd.rmw_fin) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result is only loaded when the output register is free or draining.
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.look_fin || cmd.rmw_fin) |-> out_free)
    else $error("result loaded over a waiting result");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !in_fire)
    else $error("item accepted during clearing pass");

  a_rmw_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMW) |-> ($past(cmd.arc_rd) || $past(state_r == S_RMW)))
    else $error("accumulator update without a pair read");

  a_arc_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.arc_rd |-> (sts.opcode == OP_ARC))
    else $error("pair read issued for a non-arc item");

endmodule

// File: src/cgc_dpath.sv
module cgc_dpath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [cgc_pkg::CC_W-1:0] cfg_wdata,
  input  cgc_pkg::item_t           in_item,
  input  cgc_pkg::cmd_t            cmd,
  output cgc_pkg::sts_t            sts,
  output cgc_pkg::result_t         res
);
  import cgc_pkg::*;

  logic [CLU_W-1:0]       node_mem [MAX_NODES];
  logic [CNT_W-1:0]       cnt_mem  [MAX_CLUSTERS];
  logic [WGT_W:0]         pair_mem [PAIR_DEPTH];  // {present, weight}

  item_t                  item_r;
  logic [CC_W-1:0]        cc_r;
  logic [CNT_W-1:0]       pair_total_r;
  logic [CLU_W-1:0]       nd_a_r, nd_b_r;
  logic [CNT_W-1:0]       cnt_a_r, cnt_b_r;
  logic [WGT_W:0]         pr_a_r, pr_b_r;
  result_t                res_r, res_look;

  logic [CLU_W-1:0]       cnt_ra;
  logic [PAIR_AW-1:0]     pair_ra;
  logic [PAIR_AW-1:0]     arc_idx;
  logic [WGT_W-1:0]       wsum;
  logic                   map_ok;
  logic                   first_lower;

  assign arc_idx     = {nd_a_r, nd_b_r};
  assign wsum        = pr_a_r[WGT_W-1:0] + {{(WGT_W-32){item_r.arc_weight[31]}},
                                            item_r.arc_weight};
  assign map_ok      = !clu_bad(item_r.cluster_id, cc_r);
  assign first_lower = !pr_a_r[WGT_W] && (nd_a_r < nd_b_r);

  assign sts.opcode = item_r.opcode;
  assign sts.arc_ok = (item_r.opcode == OP_ARC) && !clu_bad(nd_a_r, cc_r)
                      && !clu_bad(nd_b_r, cc_r) && (nd_a_r != nd_b_r);

  // Count port A serves the mapped cluster for a map item, else the query source.
  assign cnt_ra  = (in_item.opcode == OP_MAP) ? in_item.cluster_id : in_item.query_from;
  assign pair_ra = cmd.arc_rd ? arc_idx : {in_item.query_from, in_item.query_to};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_item;
      nd_a_r <= node_mem[in_item.first_node[NODE_AW-1:0]];
      nd_b_r <= node_mem[in_item.second_node[NODE_AW-1:0]];
    end
    if (cmd.look_fin && item_r.opcode == OP_MAP && map_ok) begin
      node_mem[item_r.first_node[NODE_AW-1:0]] <= item_r.cluster_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_a_r <= cnt_mem[cnt_ra];
      cnt_b_r <= cnt_mem[in_item.query_to];
    end
    if (cmd.clr_en) begin
      cnt_mem[cmd.clr_addr[CLU_W-1:0]] <= '0;
    end else if (cmd.look_fin && item_r.opcode == OP_MAP && map_ok) begin
      cnt_mem[item_r.cluster_id] <= sat_inc(cnt_a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.arc_rd) begin
      pr_a_r <= pair_mem[pair_ra];
    end
    if (cmd.accept) begin
      pr_b_r <= pair_mem[{in_item.query_to, in_item.query_from}];
    end
    if (cmd.clr_en) begin
      pair_mem[cmd.clr_addr] <= '0;
    end else if (cmd.rmw_fin) begin
      pair_mem[arc_idx] <= {1'b1, wsum};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r         <= CC_RESET;
      pair_total_r <= '0;
    end else begin
      if (cfg_we) begin
        cc_r <= cfg_wdata;
      end
      if (cmd.rmw_fin && first_lower) begin
        pair_total_r <= sat_inc(pair_total_r);
      end
    end
  end

  always_comb begin
    res_look        = '0;
    res_look.status = ST_OK;
    unique case (item_r.opcode)
      OP_MAP: begin
        if (!map_ok) begin
          res_look.status = ST_RANGE;
        end
      end
      OP_ARC: begin
        if (clu_bad(nd_a_r, cc_r) || clu_bad(nd_b_r, cc_r)) begin
          res_look.status = ST_RANGE;
        end else begin
          res_look.status = ST_SAME;
        end
      end
      OP_QRY: begin
        if (clu_bad(item_r.query_from, cc_r) || clu_bad(item_r.query_to, cc_r)) begin
          res_look.status = ST_RANGE;
        end else begin
          res_look.weight_forward  = pr_a_r[WGT_W-1:0];
          res_look.weight_reverse  = pr_b_r[WGT_W-1:0];
          res_look.pair_present    = pr_a_r[WGT_W];
          res_look.pair_total      = pair_total_r;
          res_look.from_node_total = cnt_a_r;
          res_look.to_node_total   = cnt_b_r;
        end
      end
      default: res_look = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.look_fin) begin
      res_r <= res_look;
    end else if (cmd.rmw_fin) begin
      res_r        <= '0;
      res_r.status <= ST_OK;
    end
  end

  assign res = res_r;

endmodule

// File: src/cluster_graph_contraction.sv
// Channel  Ports                     Direction  Contents
// in       in_tvalid/tready/tdata    input      graph items, opcode in in_tuser
// out      out_tvalid/tready/tdata   output     one result per item, status in out_tuser
// cfg      cfg_we/cfg_wdata          input      cluster_count, written on cfg_we
//
// Map, query and unused opcodes pass through accept with memory read, then lookup.
// An arc between distinct in-range clusters passes through node-to-cluster read, then
// pair accumulator read and write-back, in the order set by the registered read ports
// of the node and pair memories. After reset a clearing pass zeroes the pair and node
// count memories; in_tready stays low during it.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and its result is held in the datapath until the output register is free.
module cluster_graph_contraction (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_node[9:0], second_node[19:10], cluster_id[25:20], arc_weight[57:26],
  // query_from[63:58], query_to[69:64], zero fill[71:70]
  input  logic [71:0]  in_tdata,
  // opcode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // weight_forward[63:0], weight_reverse[127:64], pair_present[128],
  // pair_total[139:129], from_node_total[150:140], to_node_total[161:151],
  // zero fill[167:162]
  output logic [167:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser
);
  import cgc_pkg::*;

  item_t   in_item;
  result_t res;
  cmd_t    cmd;
  sts_t    sts;
  logic    in_fire;

  assign in_fire = in_tvalid && in_tready;

  assign in_item.opcode      = in_tuser;
  assign in_item.first_node  = in_tdata[9:0];
  assign in_item.second_node = in_tdata[19:10];
  assign in_item.cluster_id  = in_tdata[25:20];
  assign in_item.arc_weight  = in_tdata[57:26];
  assign in_item.query_from  = in_tdata[63:58];
  assign in_item.query_to    = in_tdata[69:64];

  assign out_tuser = res.status;
  assign out_tdata = {6'd0, res.to_node_total, res.from_node_total, res.pair_total,
                      res.pair_present, res.weight_reverse, res.weight_forward};

  cgc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_ready   (in_tready),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  cgc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res)
  );

endmodule

// File: dv/cgc_checker.sv
`timescale 1ns / 100ps

// Watches the item, result and register channels of the contraction block,
// keeps its own copy of the cluster map, pair accumulators and counters, and
// compares every result against the oldest predicted one.
module cgc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [71:0]  in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [167:0] out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           pending,
  output int           result_count
);
  import cgc_pkg::*;

  localparam int PRINT_CAP = 50;

  logic [5:0]  node_clu   [MAX_NODES];
  logic [63:0] pair_sum   [PAIR_DEPTH];
  logic        pair_seen  [PAIR_DEPTH];
  logic [10:0] clu_nodes  [MAX_CLUSTERS];
  logic [10:0] lo_hi_pairs;
  logic [6:0]  cluster_count;

  result_t expected_q[$];
  result_t seen_res;
  result_t want_res;
  int errs;
  int got_n;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errs < PRINT_CAP) begin
      $display("ERROR at %0t, result %0d: %s is %0h, expected %0h",
               $realtime, got_n, what, got, want);
    end
    errs++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Applies one item to the local state and returns the result it must produce.
  function automatic result_t apply_item(input logic [1:0] op, input logic [71:0] d);
    logic [9:0]  n1;
    logic [9:0]  n2;
    logic [5:0]  cid;
    logic [5:0]  qf;
    logic [5:0]  qt;
    logic [5:0]  a;
    logic [5:0]  b;
    logic [63:0] w;
    logic [6:0]  lim;
    logic [11:0] idx;
    result_t     r;
    n1  = d[9:0];
    n2  = d[19:10];
    cid = d[25:20];
    w   = {{32{d[57]}}, d[57:26]};
    qf  = d[63:58];
    qt  = d[69:64];
    lim = (cluster_count > 7'd64) ? 7'd64 : cluster_count;
    r   = '0;
    case (op)
      OP_MAP: begin
        if ({1'b0, cid} >= lim) begin
          r.status = ST_RANGE;
        end else begin
          node_clu[n1] = cid;
          if (clu_nodes[cid] != 11'h7FF) clu_nodes[cid] = clu_nodes[cid] + 11'd1;
        end
      end
      OP_ARC: begin
        a = node_clu[n1];
        b = node_clu[n2];
        if ({1'b0, a} >= lim || {1'b0, b} >= lim) begin
          r.status = ST_RANGE;
        end else if (a == b) begin
          r.status = ST_SAME;
        end else begin
          idx = {a, b};
          pair_sum[idx] = pair_sum[idx] + w;
          if (!pair_seen[idx]) begin
            pair_seen[idx] = 1'b1;
            // Only the lower-to-higher direction counts as a new unordered pair.
            if (a < b && lo_hi_pairs != 11'h7FF) lo_hi_pairs = lo_hi_pairs + 11'd1;
          end
        end
      end
      OP_QRY: begin
        if ({1'b0, qf} >= lim || {1'b0, qt} >= lim) begin
          r.status = ST_RANGE;
        end else begin
          r.weight_forward  = pair_sum[{qf, qt}];
          r.weight_reverse  = pair_sum[{qt, qf}];
          r.pair_present    = pair_seen[{qf, qt}];
          r.pair_total      = lo_hi_pairs;
          r.from_node_total = clu_nodes[qf];
          r.to_node_total   = clu_nodes[qt];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) node_clu[i] = '0;
      for (int i = 0; i < PAIR_DEPTH; i++) begin
        pair_sum[i]  = '0;
        pair_seen[i] = 1'b0;
      end
      for (int i = 0; i < MAX_CLUSTERS; i++) clu_nodes[i] = '0;
      lo_hi_pairs   = '0;
      cluster_count = CC_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) cluster_count = cfg_wdata;
      if (in_tvalid && in_tready) expected_q.push_back(apply_item(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got_n++;
        seen_res.status          = out_tuser;
        seen_res.weight_forward  = out_tdata[63:0];
        seen_res.weight_reverse  = out_tdata[127:64];
        seen_res.pair_present    = out_tdata[128];
        seen_res.pair_total      = out_tdata[139:129];
        seen_res.from_node_total = out_tdata[150:140];
        seen_res.to_node_total   = out_tdata[161:151];
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, status", 64'(out_tuser), '0);
        end else begin
          want_res = expected_q.pop_front();
          check_field("status", 64'(seen_res.status), 64'(want_res.status));
          check_field("weight_forward", seen_res.weight_forward, want_res.weight_forward);
          check_field("weight_reverse", seen_res.weight_reverse, want_res.weight_reverse);
          check_field("pair_present", 64'(seen_res.pair_present),
                      64'(want_res.pair_present));
          check_field("pair_total", 64'(seen_res.pair_total), 64'(want_res.pair_total));
          check_field("from_node_total", 64'(seen_res.from_node_total),
                      64'(want_res.from_node_total));
          check_field("to_node_total", 64'(seen_res.to_node_total),
                      64'(want_res.to_node_total));
        end
      end
    end
    fail_count   <= errs;
    pending      <= expected_q.size();
    result_count <= got_n;
  end

endmodule

// File: dv/cluster_graph_contraction_tb.sv
`timescale 1ns / 100ps

module cluster_graph_contraction_tb;
  import cgc_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 100;
  localparam int         HOT_CLUSTER = 9;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         cfg_we     = 1'b0;
  logic [6:0]   cfg_wdata  = '0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata   = '0;
  logic [1:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic [1:0]   out_tuser;

  int fail_count;
  int pending;
  int result_count;

  int cur_cc = 64;
  int burst_left;
  int sent_n;
  int settings_n = 1;
  int cycle_n;
  int stall_mode;
  int stall_left;
  bit mapped [MAX_NODES];
  int mapped_nodes[$];

  cluster_graph_contraction i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cgc_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_n, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: ready always, ready at random, or mostly stalled, with the mode drawn
  // anew at random whenever the current one runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic send(input logic [1:0] op, input logic [9:0] n1, input logic [9:0] n2,
                      input logic [5:0] cid, input logic [31:0] w,
                      input logic [5:0] qf, input logic [5:0] qt);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, qt, qf, w, cid, n2, n1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_n++;
    // Arcs are only ever drawn from nodes that have really been mapped.
    if (op == OP_MAP && int'(cid) < cur_cc && !mapped[n1]) begin
      mapped[n1] = 1'b1;
      mapped_nodes.push_back(int'(n1));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_clusters(input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= 7'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cc = value;
    settings_n++;
  endtask

  function automatic logic [5:0] pick_cluster();
    if (cur_cc < 64 && $urandom_range(0, 6) == 0) return 6'($urandom_range(cur_cc, 63));
    return 6'($urandom_range(0, cur_cc - 1));
  endfunction

  function automatic logic [31:0] rand_weight();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom();
    if (pick < 7) return $urandom_range(0, 200) - 100;
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  task automatic random_item();
    int unsigned pick;
    logic [9:0]  n1;
    logic [9:0]  n2;
    logic [5:0]  cid;
    logic [5:0]  qf;
    logic [5:0]  qt;
    pick = $urandom_range(0, 99);
    n1   = 10'($urandom());
    n2   = 10'($urandom());
    cid  = 6'($urandom());
    qf   = 6'($urandom());
    qt   = 6'($urandom());
    if (pick < 30 || mapped_nodes.size() == 0) begin
      // Half of the maps land on a small node set so that remapping is common.
      if ($urandom_range(0, 1) == 1) n1 = 10'($urandom_range(0, 31));
      send(OP_MAP, n1, n2, pick_cluster(), $urandom(), qf, qt);
    end else if (pick < 65) begin
      n1 = 10'(mapped_nodes[$urandom_range(0, mapped_nodes.size() - 1)]);
      n2 = 10'(mapped_nodes[$urandom_range(0, mapped_nodes.size() - 1)]);
      send(OP_ARC, n1, n2, cid, rand_weight(), qf, qt);
    end else if (pick < 95) begin
      qf = pick_cluster();
      qt = ($urandom_range(0, 9) == 0) ? qf : pick_cluster();
      send(OP_QRY, n1, n2, cid, $urandom(), qf, qt);
    end else begin
      send(OP_UNUSED, n1, n2, cid, $urandom(), qf, qt);
    end
  endtask

  initial begin
    int phase_cc [6];
    phase_cc = '{8, 1, 64, 3, 0, 17};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes of nodes, clusters and weights at the reset cluster count.
    send(OP_MAP, 10'd0,    10'd0, 6'd0,  32'd0, 6'd0, 6'd0);
    send(OP_MAP, 10'd1023, 10'd0, 6'd63, 32'd0, 6'd0, 6'd0);
    send(OP_MAP, 10'd5,    10'd0, 6'd1,  32'd0, 6'd0, 6'd0);
    send(OP_MAP, 10'd6,    10'd0, 6'd1,  32'd0, 6'd0, 6'd0);
    send(OP_ARC, 10'd1023, 10'd5, 6'd0, 32'h7FFF_FFFF, 6'd0, 6'd0);
    send(OP_ARC, 10'd1023, 10'd5, 6'd0, 32'h7FFF_FFFF, 6'd0, 6'd0);
    send(OP_ARC, 10'd5, 10'd1023, 6'd0, 32'h8000_0000, 6'd0, 6'd0);
    send(OP_ARC, 10'd0, 10'd1023, 6'd0, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send(OP_ARC, 10'd5, 10'd6,    6'd0, 32'd1, 6'd0, 6'd0);
    send(OP_ARC, 10'd1023, 10'd0, 6'd0, 32'd0, 6'd0, 6'd0);
    send(OP_QRY, 10'd0, 10'd0, 6'd0, 32'd0, 6'd63, 6'd1);
    send(OP_QRY, 10'd0, 10'd0, 6'd0, 32'd0, 6'd1,  6'd63);
    send(OP_QRY, 10'd0, 10'd0, 6'd0, 32'd0, 6'd0,  6'd63);
    send(OP_QRY, 10'd0, 10'd0, 6'd0, 32'd0, 6'd1,  6'd1);
    send(OP_QRY, 10'd0, 10'd0, 6'd0, 32'd0, 6'd63, 6'd63);
    send(OP_UNUSED, 10'h3FF, 10'h3FF, 6'h3F, 32'hFFFF_FFFF, 6'h3F, 6'h3F);
    // Remapping counts the node again without lowering its old cluster.
    send(OP_MAP, 10'd0, 10'd0, 6'd2, 32'd0, 6'd0, 6'd0);
    send(OP_QRY, 10'd0, 10'd0, 6'd0, 32'd0, 6'd0, 6'd2);

    // With two clusters, cluster 63 and cluster 2 fall out of range.
    set_clusters(2);
    send(OP_MAP, 10'd7, 10'd0, 6'd2,  32'd0, 6'd0, 6'd0);
    send(OP_MAP, 10'd8, 10'd0, 6'd63, 32'd0, 6'd0, 6'd0);
    send(OP_QRY, 10'd0, 10'd0, 6'd0, 32'd0, 6'd0, 6'd2);
    send(OP_QRY, 10'd0, 10'd0, 6'd0, 32'd0, 6'd2, 6'd0);
    send(OP_ARC, 10'd1023, 10'd5, 6'd0, 32'd3, 6'd0, 6'd0);
    send(OP_ARC, 10'd5,    10'd0, 6'd0, 32'd3, 6'd0, 6'd0);
    send(OP_QRY, 10'd0, 10'd0, 6'd0, 32'd0, 6'd0, 6'd1);

    foreach (phase_cc[p]) begin
      set_clusters((phase_cc[p] == 0) ? $urandom_range(1, 64) : phase_cc[p]);
      repeat (PHASE_ITEMS) random_item();
    end

    // Pile many remapped nodes from the top node range into one cluster.
    set_clusters(64);
    repeat (40) begin
      send(OP_MAP, 10'($urandom_range(960, 1023)), 10'($urandom()), 6'(HOT_CLUSTER),
           $urandom(), 6'($urandom()), 6'($urandom()));
    end
    repeat (10) begin
      send(OP_QRY, 10'($urandom()), 10'($urandom()), 6'($urandom()), $urandom(),
           6'(HOT_CLUSTER), pick_cluster());
      send(OP_QRY, 10'($urandom()), 10'($urandom()), 6'($urandom()), $urandom(),
           pick_cluster(), 6'(HOT_CLUSTER));
    end
    repeat (60) random_item();

    drain();
    $display("Covered %0d items (map, arc, query, unused opcode) over %0d cluster counts.",
             sent_n, settings_n);
    $display("Compared %0d results, including a heavily remapped cluster.", result_count);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
